// ===== sv/assert_macros.svh =====
// assertion helpers for the circumcenter block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked while out of reset
`define TCC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error("check failed");
// checked at every edge, reset included
`define TCC_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("check failed");
`else
`define TCC_ASSERT(lbl, prop)
`define TCC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== sv/tcc_pkg.sv =====
package tcc_pkg;
	localparam int CoordW = 32;
	localparam int NumW   = 99;   // numerator width, signed
	localparam int DenW   = 68;   // divisor width, signed and magnitude
	localparam int QW     = 33;   // quotient bits kept by the divider
	localparam int Cells  = QW;   // one quotient bit per cell
	localparam int InW    = 6 * CoordW;

	typedef struct packed {
		logic degen;
		logic negu;
		logic negv;
		logic ovfu;
		logic ovfv;
	} side_t;

	typedef struct packed {
		logic [DenW-1:0] den;
		logic [DenW-1:0] ru;
		logic [DenW-1:0] rv;
		logic [QW-1:0]   lu;
		logic [QW-1:0]   lv;
		logic [QW-1:0]   qu;
		logic [QW-1:0]   qv;
		side_t           side;
	} cell_t;
endpackage

// ===== sv/tcc_prep.sv =====
module tcc_prep (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic [tcc_pkg::InW-1:0] in_data,
	output logic                   out_vld,
	output tcc_pkg::cell_t         dout
);
	import tcc_pkg::*;

	logic signed [CoordW-1:0] ix [3];
	logic signed [CoordW-1:0] iy [3];

	logic signed [CoordW-1:0] x_s1 [3];
	logic signed [CoordW-1:0] y_s1 [3];
	logic signed [CoordW:0]   dx_s1 [3];
	logic signed [CoordW:0]   dy_s1 [3];

	logic signed [64:0]       pd_s2 [3];
	logic [62:0]              sqx_s2 [3];
	logic [62:0]              sqy_s2 [3];
	logic signed [CoordW:0]   dx_s2 [3];
	logic signed [CoordW:0]   dy_s2 [3];

	logic signed [DenW-1:0]   d_s3;
	logic [63:0]              a_s3 [3];
	logic signed [CoordW:0]   dx_s3 [3];
	logic signed [CoordW:0]   dy_s3 [3];

	logic signed [DenW-1:0]   d_s4, d_s5, d_s6;
	logic signed [65:0]       ulo_s4 [3];
	logic signed [65:0]       uhi_s4 [3];
	logic signed [65:0]       vlo_s4 [3];
	logic signed [65:0]       vhi_s4 [3];

	logic signed [NumW-1:0]   tu_s5 [3];
	logic signed [NumW-1:0]   tv_s5 [3];
	logic signed [NumW-1:0]   nu_s6, nv_s6;

	logic [NumW-1:0]          nu_s7, nv_s7;
	logic [DenW-1:0]          d_s7;
	logic                     degen_s7, negu_s7, negv_s7;

	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	cell_t                    cell_s8;
	logic signed [66:0]       dsum;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ix[k] = in_data[2*k*CoordW +: CoordW];
			iy[k] = in_data[(2*k+1)*CoordW +: CoordW];
		end
	end

	assign dsum = 67'(pd_s2[0]) + 67'(pd_s2[1]) + 67'(pd_s2[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// differences: index 0 pairs with vertex one, and so on
			for (int k = 0; k < 3; k++) begin
				x_s1[k] <= ix[k];
				y_s1[k] <= iy[k];
			end
			dx_s1[0] <= 33'(ix[1]) - 33'(ix[2]);
			dx_s1[1] <= 33'(ix[2]) - 33'(ix[0]);
			dx_s1[2] <= 33'(ix[0]) - 33'(ix[1]);
			dy_s1[0] <= 33'(iy[2]) - 33'(iy[1]);
			dy_s1[1] <= 33'(iy[0]) - 33'(iy[2]);
			dy_s1[2] <= 33'(iy[1]) - 33'(iy[0]);

			for (int k = 0; k < 3; k++) begin
				pd_s2[k]  <= 65'(y_s1[k]) * 65'(dx_s1[k]);
				sqx_s2[k] <= 63'(64'(x_s1[k]) * 64'(x_s1[k]));
				sqy_s2[k] <= 63'(64'(y_s1[k]) * 64'(y_s1[k]));
				dx_s2[k]  <= dx_s1[k];
				dy_s2[k]  <= dy_s1[k];
			end

			d_s3 <= {dsum, 1'b0};
			for (int k = 0; k < 3; k++) begin
				a_s3[k]  <= 64'(sqx_s2[k]) + 64'(sqy_s2[k]);
				dx_s3[k] <= dx_s2[k];
				dy_s3[k] <= dy_s2[k];
			end

			// split each squared norm into 32-bit halves
			d_s4 <= d_s3;
			for (int k = 0; k < 3; k++) begin
				ulo_s4[k] <= 66'($signed({1'b0, a_s3[k][31:0]})) * 66'(dy_s3[k]);
				uhi_s4[k] <= 66'($signed({1'b0, a_s3[k][63:32]})) * 66'(dy_s3[k]);
				vlo_s4[k] <= 66'($signed({1'b0, a_s3[k][31:0]})) * 66'(dx_s3[k]);
				vhi_s4[k] <= 66'($signed({1'b0, a_s3[k][63:32]})) * 66'(dx_s3[k]);
			end

			d_s5 <= d_s4;
			for (int k = 0; k < 3; k++) begin
				tu_s5[k] <= (99'(uhi_s4[k]) <<< 32) + 99'(ulo_s4[k]);
				tv_s5[k] <= (99'(vhi_s4[k]) <<< 32) + 99'(vlo_s4[k]);
			end

			d_s6  <= d_s5;
			nu_s6 <= tu_s5[0] + tu_s5[1] + tu_s5[2];
			nv_s6 <= tv_s5[0] + tv_s5[1] + tv_s5[2];

			// magnitudes and quotient signs
			nu_s7    <= nu_s6[NumW-1] ? NumW'(-nu_s6) : NumW'(nu_s6);
			nv_s7    <= nv_s6[NumW-1] ? NumW'(-nv_s6) : NumW'(nv_s6);
			d_s7     <= d_s6[DenW-1] ? DenW'(-d_s6) : DenW'(d_s6);
			negu_s7  <= nu_s6[NumW-1] ^ d_s6[DenW-1];
			negv_s7  <= nv_s6[NumW-1] ^ d_s6[DenW-1];
			degen_s7 <= (d_s6 == '0);

			// quotient of 2^33 or more is out of range at once
			cell_s8.den        <= d_s7;
			cell_s8.ru         <= DenW'(nu_s7[NumW-1:QW]);
			cell_s8.rv         <= DenW'(nv_s7[NumW-1:QW]);
			cell_s8.lu         <= nu_s7[QW-1:0];
			cell_s8.lv         <= nv_s7[QW-1:0];
			cell_s8.qu         <= '0;
			cell_s8.qv         <= '0;
			cell_s8.side.degen <= degen_s7;
			cell_s8.side.negu  <= negu_s7;
			cell_s8.side.negv  <= negv_s7;
			cell_s8.side.ovfu  <= (DenW'(nu_s7[NumW-1:QW]) >= d_s7);
			cell_s8.side.ovfv  <= (DenW'(nv_s7[NumW-1:QW]) >= d_s7);
		end
	end

	assign out_vld = vld_s8;
	assign dout    = cell_s8;
endmodule

// ===== sv/tcc_cell.sv =====
module tcc_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  tcc_pkg::cell_t din,
	output logic           out_vld,
	output tcc_pkg::cell_t dout
);
	import tcc_pkg::*;

	logic [DenW:0] tu, tv, dext;
	logic          geu, gev;
	logic          vld_q;
	cell_t         cell_q;

	// bring down the next numerator bit, try one subtract per lane
	assign tu   = {din.ru, din.lu[QW-1]};
	assign tv   = {din.rv, din.lv[QW-1]};
	assign dext = {1'b0, din.den};
	assign geu  = (tu >= dext);
	assign gev  = (tv >= dext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q.den  <= din.den;
			cell_q.ru   <= geu ? DenW'(tu - dext) : tu[DenW-1:0];
			cell_q.rv   <= gev ? DenW'(tv - dext) : tv[DenW-1:0];
			cell_q.lu   <= {din.lu[QW-2:0], 1'b0};
			cell_q.lv   <= {din.lv[QW-2:0], 1'b0};
			cell_q.qu   <= {din.qu[QW-2:0], geu};
			cell_q.qv   <= {din.qv[QW-2:0], gev};
			cell_q.side <= din.side;
		end
	end

	assign out_vld = vld_q;
	assign dout    = cell_q;
endmodule

// ===== sv/triangle_circumcenter_2d.sv =====
// Circumcenter of a planar triangle. Each input item carries three vertices as
// signed Q16.16 coordinates; each output item is the center of the circle
// through them, rounded toward zero and clamped to the signed 32-bit range,
// with a saturated flag when a coordinate was clamped and a degenerate flag
// (center forced to zero) when the vertices are collinear. The block takes one
// item per cycle while the output is not stalled and returns results in order:
// first exact wide-integer arithmetic (differences, products split into 32-bit
// halves, sums, magnitudes and a range check), then a row of 33 divider cells
// that each settle one quotient bit for both coordinates, then the output
// register. The whole pipe holds while a result waits at the output, so the
// input is ready exactly when the output register is empty or being taken.
module triangle_circumcenter_2d (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// first_u, first_v, second_u, second_v, third_u, third_v (32 bits each)
	input  logic [191:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// center_u, center_v (32 bits each)
	output logic [63:0]  m_tdata,
	// degenerate, saturated
	output logic [1:0]   m_tuser
);
	import tcc_pkg::*;

	`include "assert_macros.svh"

	localparam logic [CoordW-1:0] MaxPos = {1'b0, {(CoordW-1){1'b1}}};
	localparam logic [CoordW-1:0] MaxNeg = {1'b1, {(CoordW-1){1'b0}}};

	logic        en;
	logic        chain_vld [Cells+1];
	cell_t       chain [Cells+1];
	cell_t       last;

	logic [CoordW-1:0] cu, cv;
	logic              satu, satv;

	logic        out_vld_q;
	logic [63:0] tdata_q;
	logic [1:0]  tuser_q;

	// every stage moves together unless a result is stuck at the output
	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	tcc_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_tvalid),
		.in_data (s_tdata),
		.out_vld (chain_vld[0]),
		.dout    (chain[0])
	);

	// one cell per quotient bit, most significant first
	for (genvar g = 0; g < Cells; g++) begin : g_cell
		tcc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_vld  (chain_vld[g]),
			.din     (chain[g]),
			.out_vld (chain_vld[g+1]),
			.dout    (chain[g+1])
		);
	end

	assign last = chain[Cells];

	// sign and clamp; a negative quotient may reach 2^31 exactly
	always_comb begin
		if (last.side.negu) begin
			satu = last.side.ovfu || last.qu > QW'({1'b0, MaxNeg});
			cu   = satu ? MaxNeg : CoordW'(-last.qu[CoordW-1:0]);
		end else begin
			satu = last.side.ovfu || (last.qu[QW-1:CoordW-1] != '0);
			cu   = satu ? MaxPos : last.qu[CoordW-1:0];
		end
		if (last.side.negv) begin
			satv = last.side.ovfv || last.qv > QW'({1'b0, MaxNeg});
			cv   = satv ? MaxNeg : CoordW'(-last.qv[CoordW-1:0]);
		end else begin
			satv = last.side.ovfv || (last.qv[QW-1:CoordW-1] != '0);
			cv   = satv ? MaxPos : last.qv[CoordW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= chain_vld[Cells];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (last.side.degen) begin
				tdata_q <= '0;
				tuser_q <= 2'b01;
			end else begin
				tdata_q <= {cv, cu};
				tuser_q <= {satu || satv, 1'b0};
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;

	`TCC_ASSERT_ALWAYS(a_ready_follows_output, s_tready == (!m_tvalid || m_tready))
	`TCC_ASSERT(a_degen_zero, m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
	`TCC_ASSERT(a_sat_clamped, m_tvalid && m_tuser[1] |->
		m_tdata[31:0] == MaxPos || m_tdata[31:0] == MaxNeg ||
		m_tdata[63:32] == MaxPos || m_tdata[63:32] == MaxNeg)
	`TCC_ASSERT(a_hold_when_stalled, m_tvalid && !m_tready |=> $stable(chain_vld[Cells]))
endmodule

// ===== dv/triangle_circumcenter_2d_chk.sv =====
`timescale 1ns / 100ps

module triangle_circumcenter_2d_chk (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [191:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [63:0]  m_tdata,
	input  logic [1:0]   m_tuser,
	output int           errors,
	output int           pending
);

	typedef struct packed {
		logic [31:0] center_v;
		logic [31:0] center_u;
		logic        saturated;
		logic        degenerate;
	} center_t;

	center_t centers_due[$];
	int      err_cnt = 0;

	// quotient rounded toward zero, clamped to 32 bits
	function automatic logic [31:0] clamp_quot(input logic signed [127:0] num,
			input logic signed [127:0] den, inout logic sat);
		logic signed [127:0] q;
		q = num / den;
		if (q > 128'sh7FFF_FFFF) begin
			sat = 1'b1;
			return 32'h7FFF_FFFF;
		end
		if (q < -128'sh8000_0000) begin
			sat = 1'b1;
			return 32'h8000_0000;
		end
		return q[31:0];
	endfunction

	function automatic center_t circumcenter(input logic [191:0] tri_in);
		logic signed [127:0] u1, v1, u2, v2, u3, v3, den, nu, nv, a1, a2, a3;
		center_t c;
		logic sat;
		u1 = $signed(tri_in[31:0]);
		v1 = $signed(tri_in[63:32]);
		u2 = $signed(tri_in[95:64]);
		v2 = $signed(tri_in[127:96]);
		u3 = $signed(tri_in[159:128]);
		v3 = $signed(tri_in[191:160]);
		c = '0;
		sat = 1'b0;
		den = 2 * (v1 * (u2 - u3) + v2 * (u3 - u1) + v3 * (u1 - u2));
		if (den == 0) begin
			c.degenerate = 1'b1;
			return c;
		end
		a1 = u1 * u1 + v1 * v1;
		a2 = u2 * u2 + v2 * v2;
		a3 = u3 * u3 + v3 * v3;
		nu = a1 * (v3 - v2) + a2 * (v1 - v3) + a3 * (v2 - v1);
		nv = a1 * (u2 - u3) + a2 * (u3 - u1) + a3 * (u1 - u2);
		c.center_u = clamp_quot(nu, den, sat);
		c.center_v = clamp_quot(nv, den, sat);
		c.saturated = sat;
		return c;
	endfunction

	assign errors = err_cnt;

	// sampled mid-cycle, so values seen here are the ones taken at the next rising edge
	always @(negedge clk) begin
		center_t want;
		if (arst_n && s_tvalid && s_tready)
			centers_due.push_back(circumcenter(s_tdata));
		if (arst_n && m_tvalid && m_tready) begin
			if (centers_due.size() == 0) begin
				$error("result with nothing expected: %h %b", m_tdata, m_tuser);
				err_cnt++;
			end else begin
				want = centers_due.pop_front();
				if (m_tdata[31:0] !== want.center_u) begin
					$error("center_u expected %h actual %h", want.center_u, m_tdata[31:0]);
					err_cnt++;
				end
				if (m_tdata[63:32] !== want.center_v) begin
					$error("center_v expected %h actual %h", want.center_v, m_tdata[63:32]);
					err_cnt++;
				end
				if (m_tuser[0] !== want.degenerate) begin
					$error("degenerate expected %b actual %b", want.degenerate, m_tuser[0]);
					err_cnt++;
				end
				if (m_tuser[1] !== want.saturated) begin
					$error("saturated expected %b actual %b", want.saturated, m_tuser[1]);
					err_cnt++;
				end
			end
		end
		pending = centers_due.size();
	end

endmodule

// ===== dv/triangle_circumcenter_2d_tb.sv =====
`timescale 1ns / 100ps

module triangle_circumcenter_2d_tb;

	localparam int IdleLimit = 3000;   // cycles with no item moving on either side
	localparam int HoldCycles = 300;   // long receiver hold-off, fills the pipe

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [191:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic [1:0]   m_tuser;
	int           errors;
	int           pending;

	// handshakes seen mid-cycle, valid at the following rising edge
	logic in_taken;
	logic out_taken;

	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_req;

	triangle_circumcenter_2d dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	triangle_circumcenter_2d_chk chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(negedge clk) begin
		in_taken  <= arst_n && s_tvalid && s_tready;
		out_taken <= arst_n && m_tvalid && m_tready;
	end

	// offer one triangle, vertices packed from the first u in the low bits up
	task automatic offer_triangle(input logic [31:0] u1, v1, u2, v2, u3, v3);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {v3, u3, v2, u2, v1, u1};
		@(posedge clk);
		while (!in_taken)
			@(posedge clk);
	endtask

	function automatic logic [31:0] near(input int span);
		return $urandom_range(2 * span) - span;
	endfunction

	// random triangle: small ones, raw noise, moderate sizes, collinear and coincident sets
	task automatic offer_random();
		logic [31:0] u1, v1, u2, v2, u3, v3;
		int k;
		int pick;
		pick = $urandom_range(99);
		u1 = near(1 << 20);
		v1 = near(1 << 20);
		u2 = near(1 << 20);
		v2 = near(1 << 20);
		u3 = near(1 << 20);
		v3 = near(1 << 20);
		if (pick < 30) begin
			// full range, every bit toggles
			u1 = $urandom; v1 = $urandom; u2 = $urandom;
			v2 = $urandom; u3 = $urandom; v3 = $urandom;
		end else if (pick < 40) begin
			// moderate sizes in the middle of the range
			u1 = near(1 << 28); v1 = near(1 << 28); u2 = near(1 << 28);
			v2 = near(1 << 28); u3 = near(1 << 28); v3 = near(1 << 28);
		end else if (pick < 55) begin
			// collinear: third vertex on the line through the first two
			u1 = near(1 << 16); v1 = near(1 << 16);
			u2 = near(1 << 16); v2 = near(1 << 16);
			k = $urandom_range(8) - 4;
			u3 = u1 + k * (u2 - u1);
			v3 = v1 + k * (v2 - v1);
		end else if (pick < 62) begin
			// two vertices coincide
			u3 = u1;
			v3 = v1;
		end else if (pick < 72) begin
			// almost collinear with a long base, quotient leaves the range
			u1 = 32'h8000_0000 + $urandom_range(255);
			u2 = 32'h7FFF_FFFF - $urandom_range(255);
			v1 = near(2);
			v2 = near(2);
			u3 = $urandom;
			v3 = near(3);
		end
		offer_triangle(u1, v1, u2, v2, u3, v3);
	endtask

	// receiver: random stalls, and one long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HoldCycles)
					@(posedge clk);
				hold_req = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog on cycles where nothing moves
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			quiet = (in_taken || out_taken) ? 0 : quiet + 1;
			if (quiet >= IdleLimit) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		arst_n         = 1'b0;
		hold_req       = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: all zero, collinear and coincident sets
		offer_triangle(0, 0, 0, 0, 0, 0);
		offer_triangle(32'h0001_0000, 0, 32'h0002_0000, 0, 32'h0003_0000, 0);
		offer_triangle(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
				32'h0005_0000, 32'h0007_0000);
		offer_triangle(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
				32'h8000_0000, 32'h8000_0000);
		// right triangles with exact centers, the second on the unit circle
		offer_triangle(0, 0, 32'h0002_0000, 0, 0, 32'h0002_0000);
		offer_triangle(32'hFFFF_0000, 0, 32'h0001_0000, 0, 0, 32'h0001_0000);
		// center with fractional and negative parts, truncation toward zero
		offer_triangle(0, 0, 32'h0000_0003, 0, 0, 32'hFFFF_FFF9);
		offer_triangle(1, 0, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// corners of the range
		offer_triangle(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
				32'h8000_0000, 32'h7FFF_FFFF);
		offer_triangle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
				32'h7FFF_FFFF, 32'h8000_0000);
		offer_triangle(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF);
		offer_triangle(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
				32'h0000_0001, 32'hFFFF_FFFF);
		// long thin triangles: center clamped high and low
		offer_triangle(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 1);
		offer_triangle(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF);
		offer_triangle(0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 1, 0);
		offer_triangle(0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
		offer_triangle(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
				0, 1);
		offer_triangle(32'h4000_0000, 0, 32'hC000_0000, 0, 0, 32'h0000_0002);
		// one ulp triangle at the origin
		offer_triangle(0, 0, 1, 0, 0, 1);

		// random, phased idling
		repeat (130)
			offer_random();
		send_idle_pct = 48;
		repeat (130)
			offer_random();
		send_idle_pct  = 0;
		recv_stall_pct = 48;
		repeat (130)
			offer_random();
		send_idle_pct = 25;
		recv_stall_pct = 25;
		repeat (130)
			offer_random();
		// long receiver hold-off while the sender keeps offering
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b1;
		repeat (130)
			offer_random();
		s_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (60)
			@(posedge clk);
		if (errors == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/tcc_pkg.sv
sv/tcc_prep.sv
sv/tcc_cell.sv
sv/triangle_circumcenter_2d.sv
dv/triangle_circumcenter_2d_chk.sv
dv/triangle_circumcenter_2d_tb.sv
